[sv/itp_pkg.sv]
// Shared types, constants and helpers for the infix-to-postfix converter.
// No dependencies; used by every module of the block except itp_ram.
package itp_pkg;

    localparam int SYM_W           = 8;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int OP_W            = 2;

    // ASCII codes of the operator symbols and the terminator
    localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_TERM = 8'h00;

    // stacked operator codes; bit 1 set means high precedence
    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FETCH,
        ST_TERM
    } t_state;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_OPERAND,
        EMIT_POPPED,
        EMIT_TERM
    } t_emit;

    // controller -> datapath
    typedef struct packed {
        logic  latch_in;
        t_emit emit;
        logic  emit_last;
        logic  pop;
        logic  push;
        logic  load_top;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_end;
        logic in_is_op;
        logic slot_free;
        logic empty;
        logic pop_now;
        logic pop_again;
        logic flush;
    } t_stat;

    function automatic logic f_is_op(input logic [SYM_W-1:0] sym);
        return (sym == CH_ADD) || (sym == CH_SUB) || (sym == CH_MUL) || (sym == CH_DIV);
    endfunction

    function automatic t_op f_op_code(input logic [SYM_W-1:0] sym);
        t_op code;
        unique case (sym)
            CH_SUB:  code = OP_SUB;
            CH_MUL:  code = OP_MUL;
            CH_DIV:  code = OP_DIV;
            default: code = OP_ADD;
        endcase
        return code;
    endfunction

    function automatic logic [SYM_W-1:0] f_op_char(input t_op code);
        logic [SYM_W-1:0] ch;
        unique case (code)
            OP_ADD: ch = CH_ADD;
            OP_SUB: ch = CH_SUB;
            OP_MUL: ch = CH_MUL;
            OP_DIV: ch = CH_DIV;
        endcase
        return ch;
    endfunction

endpackage

[sv/itp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/itp_ctrl.sv]
// Sequencer of the infix-to-postfix converter: accept, pop, fetch, terminate.
// Depends on itp_pkg; drives itp_dp through t_cmd and reads t_stat back.
module itp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  itp_pkg::t_stat i_stat,
    output itp_pkg::t_cmd  o_cmd
);

    itp_pkg::t_state r_state;
    itp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_s_tready       = 1'b0;
        o_cmd.latch_in   = 1'b0;
        o_cmd.emit       = itp_pkg::EMIT_NONE;
        o_cmd.emit_last  = 1'b0;
        o_cmd.pop        = 1'b0;
        o_cmd.push       = 1'b0;
        o_cmd.load_top   = 1'b0;

        unique case (r_state)
            itp_pkg::ST_IDLE: begin
                // operands go straight to the output register, so wait for a free slot
                o_s_tready = i_stat.slot_free;
                if (i_s_tvalid && i_stat.slot_free) begin
                    if (i_stat.in_end || i_stat.in_is_op) begin
                        o_cmd.latch_in = 1'b1;
                        n_state        = itp_pkg::ST_POP;
                    end else begin
                        o_cmd.emit      = itp_pkg::EMIT_OPERAND;
                        o_cmd.emit_last = 1'b1;
                    end
                end
            end
            itp_pkg::ST_POP: begin
                if (i_stat.pop_now) begin
                    o_cmd.pop = 1'b1;
                    n_state   = itp_pkg::ST_FETCH;
                end else if (i_stat.flush) begin
                    n_state = itp_pkg::ST_TERM;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = itp_pkg::ST_IDLE;
                end
            end
            itp_pkg::ST_FETCH: begin
                // new top arrives from RAM; popped symbol waits here until output is free
                o_cmd.load_top = 1'b1;
                if (i_stat.slot_free) begin
                    o_cmd.emit      = itp_pkg::EMIT_POPPED;
                    o_cmd.emit_last = !i_stat.pop_again && !i_stat.flush;
                    if (i_stat.pop_again) begin
                        n_state = itp_pkg::ST_POP;
                    end else if (i_stat.flush) begin
                        n_state = itp_pkg::ST_TERM;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = itp_pkg::ST_IDLE;
                    end
                end
            end
            itp_pkg::ST_TERM: begin
                if (i_stat.slot_free) begin
                    o_cmd.emit      = itp_pkg::EMIT_TERM;
                    o_cmd.emit_last = 1'b1;
                    n_state         = itp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[sv/itp_dp.sv]
// Datapath of the infix-to-postfix converter: operator stack, level, flags,
// output register. Depends on itp_pkg and itp_ram.
module itp_dp #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [itp_pkg::SYM_W-1:0] i_s_tdata,
    input  logic                     i_s_tlast,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [itp_pkg::SYM_W-1:0] o_m_tdata,
    output logic                     o_m_tlast,
    output logic [1:0]               o_m_tuser,
    input  itp_pkg::t_cmd             i_cmd,
    output itp_pkg::t_stat            o_stat
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam logic [LW-1:0] LVL_FULL = LW'(STACK_DEPTH);
    localparam logic [LW-1:0] LVL_ONE  = LW'(1);

    logic [LW-1:0]  r_level;
    logic [LW-1:0]  n_level;
    logic           r_ovf;
    itp_pkg::t_op   r_code;
    logic           r_flush;
    itp_pkg::t_op   r_top;
    itp_pkg::t_op   r_pend;
    logic [LW-1:0]  rd_level;
    logic [itp_pkg::OP_W-1:0] rd_data;
    logic           full;
    logic           push_ok;

    logic                      r_out_valid;
    logic [itp_pkg::SYM_W-1:0] r_out_data;
    logic                      r_out_last;
    logic                      r_out_done;
    logic                      r_out_drop;

    assign full    = (r_level == LVL_FULL);
    assign push_ok = i_cmd.push && !full;

    always_comb begin
        priority if (i_cmd.pop) begin
            n_level = r_level - LVL_ONE;
        end else if (push_ok) begin
            n_level = r_level + LVL_ONE;
        end else begin
            n_level = r_level;
        end
    end

    // read the entry just below the next level, so it is ready in the cycle after a pop
    assign rd_level = n_level - LVL_ONE;

    itp_ram #(
        .WIDTH (itp_pkg::OP_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_level[AW-1:0]),
        .i_wdata (r_code),
        .i_raddr (rd_level[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_level <= n_level;
            if (i_cmd.push && full) begin
                r_ovf <= 1'b1;
            end else if (i_cmd.emit == itp_pkg::EMIT_TERM) begin
                r_ovf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_code  <= itp_pkg::f_op_code(i_s_tdata);
            r_flush <= i_s_tlast;
        end
        if (i_cmd.pop) begin
            r_pend <= r_top;
        end
        if (push_ok) begin
            r_top <= r_code;
        end else if (i_cmd.load_top) begin
            r_top <= itp_pkg::t_op'(rd_data);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit != itp_pkg::EMIT_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.emit)
            itp_pkg::EMIT_OPERAND: begin
                r_out_data <= i_s_tdata;
                r_out_done <= 1'b0;
                r_out_drop <= 1'b0;
            end
            itp_pkg::EMIT_POPPED: begin
                r_out_data <= itp_pkg::f_op_char(r_pend);
                r_out_done <= 1'b0;
                r_out_drop <= 1'b0;
            end
            itp_pkg::EMIT_TERM: begin
                r_out_data <= itp_pkg::CH_TERM;
                r_out_done <= 1'b1;
                r_out_drop <= r_ovf;
            end
            itp_pkg::EMIT_NONE: begin
                r_out_data <= r_out_data;
            end
        endcase
        if (i_cmd.emit != itp_pkg::EMIT_NONE) begin
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_drop, r_out_done};

    // pop while the incoming precedence is not above the top's (bit 1 = high)
    assign o_stat.in_end    = i_s_tlast;
    assign o_stat.in_is_op  = itp_pkg::f_is_op(i_s_tdata);
    assign o_stat.slot_free = !r_out_valid || i_m_tready;
    assign o_stat.empty     = (r_level == '0);
    assign o_stat.flush     = r_flush;
    assign o_stat.pop_now   = (r_level != '0) && (r_flush || !r_code[1] || r_top[1]);
    assign o_stat.pop_again = (r_level != '0) && (r_flush || !r_code[1] || rd_data[1]);

endmodule

[sv/infix_to_postfix_converter.sv]
// Top level of the infix-to-postfix converter (shunting yard, no parentheses).
// Depends on itp_pkg, itp_ctrl, itp_dp and, through itp_dp, itp_ram.

// Takes one infix symbol per request on the slave side and delivers postfix
// symbols on the master side. A byte other than + - * / is an operand and
// comes out unchanged. An operator first pops every stacked operator whose
// precedence is not below its own (* / above + -), then is pushed; a push
// onto a full stack drops the operator and raises a sticky flag. A request
// with tlast set ends the expression: the stack is flushed and a zero
// terminator follows, with tuser[0] set and tuser[1] carrying the flag,
// which is then cleared. o_m_tlast marks the last result of each request;
// an operator that only pushes produces no result. The stack lives in a
// RAM with registered read, and the next stack top is fetched from it
// after every pop. A result still waiting on the master side holds
// o_s_tready low and stalls the sequencer until it is taken.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF   // 2 .. 63
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave side
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [itp_pkg::SYM_W-1:0] i_s_tdata,   // [7:0] symbol
    input  logic                      i_s_tlast,   // end_marker
    // master side
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [itp_pkg::SYM_W-1:0] o_m_tdata,   // [7:0] out_symbol
    output logic                      o_m_tlast,   // last_of_run
    output logic [1:0]                o_m_tuser    // [0] expression_done, [1] dropped_operator
);

    itp_pkg::t_cmd  cmd;
    itp_pkg::t_stat stat;

    itp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    itp_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

`ifndef SYNTHESIS
    // never pop an empty stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.pop |-> !stat.empty)
        else $error("pop issued on empty stack");

    // a result is only loaded when the output register is free
    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit != itp_pkg::EMIT_NONE) |-> stat.slot_free)
        else $error("result overwrote a pending result");

    // terminator is a zero byte closing its request
    a_term_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == itp_pkg::CH_TERM) && o_m_tlast)
        else $error("malformed terminator");

    // drop flag only travels on the terminator
    a_drop_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tuser[0])
        else $error("drop flag outside terminator");
`endif

endmodule

[tb/sv/tb_infix_to_postfix_converter.sv]
// Testbench for infix_to_postfix_converter: streams infix symbols in, checks each
// postfix result against an in-bench operator-stack predictor.
// Depends on itp_pkg and the converter RTL.
module tb_infix_to_postfix_converter;
    import itp_pkg::*;

    localparam int IDLE_LIMIT = 2000;   // cycles with no transfer before giving up
    localparam int DRAIN_WAIT = 16;     // quiet cycles after the last result

    typedef struct {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             done;
        logic             dropped;
    } postfix_out_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [SYM_W-1:0] s_tdata = '0;
    logic             s_tlast = 1'b0;
    logic             s_tready;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [SYM_W-1:0] m_tdata;
    logic             m_tlast;
    logic [1:0]       m_tuser;

    // predictor state
    t_op              op_stack [64];
    int               op_level = 0;
    bit               op_dropped = 1'b0;
    postfix_out_t     postfix_q [$];

    int               errors = 0;
    int               tx_max_gap = 8;
    int               rx_max_gap = 8;
    int               rx_hold_cycles = 0;
    int               idle_count = 0;

    always #1 i_clk = ~i_clk;

    infix_to_postfix_converter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] symbol
        .i_s_tlast  (s_tlast),    // end_marker
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] out_symbol
        .o_m_tlast  (m_tlast),    // last_of_run
        .o_m_tuser  (m_tuser)     // [0] expression_done, [1] dropped_operator
    );

    function automatic int op_rank(input t_op code);
        return (code == OP_MUL || code == OP_DIV) ? 3 : 2;
    endfunction

    function automatic logic [SYM_W-1:0] op_symbol(input t_op code);
        logic [SYM_W-1:0] ch;
        case (code)
            OP_ADD:  ch = CH_ADD;
            OP_SUB:  ch = CH_SUB;
            OP_MUL:  ch = CH_MUL;
            default: ch = CH_DIV;
        endcase
        return ch;
    endfunction

    function automatic void queue_postfix(input logic [SYM_W-1:0] sym, input logic done,
                                          input logic dropped);
        postfix_out_t r;
        r.sym     = sym;
        r.last    = 1'b0;
        r.done    = done;
        r.dropped = dropped;
        postfix_q.push_back(r);
    endfunction

    // Shunting-yard step for one accepted request; appends its results.
    function automatic void predict_postfix(input logic [SYM_W-1:0] sym, input logic endm);
        int   before_n;
        t_op  code;
        bit   is_op;
        before_n = postfix_q.size();
        is_op    = 1'b1;
        code     = OP_ADD;
        case (sym)
            CH_ADD:  code = OP_ADD;
            CH_SUB:  code = OP_SUB;
            CH_MUL:  code = OP_MUL;
            CH_DIV:  code = OP_DIV;
            default: is_op = 1'b0;
        endcase
        if (endm) begin
            while (op_level > 0) begin
                op_level--;
                queue_postfix(op_symbol(op_stack[op_level]), 1'b0, 1'b0);
            end
            queue_postfix(CH_TERM, 1'b1, op_dropped);
            op_dropped = 1'b0;
        end else if (!is_op) begin
            queue_postfix(sym, 1'b0, 1'b0);
        end else begin
            // pop while incoming precedence is not above the top
            while (op_level > 0 && op_rank(code) <= op_rank(op_stack[op_level-1])) begin
                op_level--;
                queue_postfix(op_symbol(op_stack[op_level]), 1'b0, 1'b0);
            end
            if (op_level < STACK_DEPTH_DEF) begin
                op_stack[op_level] = code;
                op_level++;
            end else begin
                op_dropped = 1'b1;
            end
        end
        if (postfix_q.size() > before_n)
            postfix_q[postfix_q.size()-1].last = 1'b1;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // One request on the slave side; valid stays high across back-to-back requests.
    task automatic send_request(input logic [SYM_W-1:0] sym, input logic endm);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tlast  <= endm;
        do @(posedge i_clk); while (!s_tready);
        predict_postfix(sym, endm);
    endtask

    function automatic logic [SYM_W-1:0] rand_operand();
        logic [SYM_W-1:0] b;
        do b = SYM_W'($urandom_range(0, 255));
        while (b == CH_ADD || b == CH_SUB || b == CH_MUL || b == CH_DIV);
        return b;
    endfunction

    function automatic logic [SYM_W-1:0] rand_operator();
        logic [SYM_W-1:0] ch;
        case ($urandom_range(0, 3))
            0:       ch = CH_ADD;
            1:       ch = CH_SUB;
            2:       ch = CH_MUL;
            default: ch = CH_DIV;
        endcase
        return ch;
    endfunction

    // operand (operator operand)* end, with an occasional stray symbol
    task automatic send_expression(input int terms, input bit noisy);
        for (int t = 0; t < terms; t++) begin
            send_request(rand_operand(), 1'b0);
            if (noisy && $urandom_range(0, 19) == 0)
                send_request(SYM_W'($urandom_range(0, 255)), 1'b0);
            if (t != terms - 1)
                send_request(rand_operator(), 1'b0);
            if (noisy && $urandom_range(0, 29) == 0)
                send_request(rand_operator(), 1'b0);
        end
        send_request(SYM_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_directed();
        send_request(8'h00, 1'b0);       // zero byte without end marker is an operand
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b1);       // terminator, empty stack
        send_request(8'h41, 1'b0);
        send_request(CH_ADD, 1'b0);      // push only, no result
        send_request(8'h42, 1'b0);
        send_request(CH_MUL, 1'b0);      // higher rank stacks on top
        send_request(8'h43, 1'b0);
        send_request(CH_SUB, 1'b0);      // pops * and +
        send_request(8'h44, 1'b0);
        send_request(CH_DIV, 1'b0);
        send_request(8'h45, 1'b0);
        send_request(CH_MUL, 1'b0);      // equal rank pops /
        send_request(8'h46, 1'b0);
        send_request(CH_MUL, 1'b1);      // symbol ignored under end marker, flush two
        send_request(CH_SUB, 1'b0);      // operator onto empty stack
        send_request(CH_ADD, 1'b0);      // pops -
        send_request(8'hFF, 1'b1);
        send_request(8'h80, 1'b0);
        send_request(8'h7F, 1'b0);
        send_request(CH_DIV, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'hAA, 1'b1);
    endtask

    task automatic test_random_expressions();
        for (int e = 0; e < 30; e++)
            send_expression($urandom_range(1, 4), 1'b1);
        // raw noise, any byte, any marker
        for (int i = 0; i < 30; i++)
            send_request(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_back_to_back();
        tx_max_gap = 0;
        rx_max_gap = 0;
        for (int e = 0; e < 6; e++)
            send_expression($urandom_range(2, 5), 1'b0);
        tx_max_gap = 8;
        rx_max_gap = 8;
    endtask

    task automatic test_receiver_holdoff();
        tx_max_gap     = 0;
        rx_hold_cycles = 300;
        for (int e = 0; e < 5; e++)
            send_expression(4, 1'b0);
        tx_max_gap = 8;
    endtask

    // master side: random ready gaps, plus the requested long hold-off
    initial begin : result_sink
        int wait_cycles;
        wait (i_rst_n);
        forever begin
            wait_cycles = $urandom_range(0, rx_max_gap);
            if (rx_hold_cycles > 0) begin
                wait_cycles    = wait_cycles + rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                for (int c = 0; c < wait_cycles; c++)
                    @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_tvalid && m_tready));
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        postfix_out_t exp_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (postfix_q.size() == 0) begin
                log_mismatch($sformatf("unexpected result sym=%02h", m_tdata));
            end else begin
                exp_r = postfix_q.pop_front();
                if (m_tdata !== exp_r.sym || m_tlast !== exp_r.last ||
                    m_tuser[0] !== exp_r.done || m_tuser[1] !== exp_r.dropped)
                    log_mismatch($sformatf(
                        "got sym=%02h last=%b done=%b drop=%b, want %02h %b %b %b",
                        m_tdata, m_tlast, m_tuser[0], m_tuser[1],
                        exp_r.sym, exp_r.last, exp_r.done, exp_r.dropped));
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_count <= 0;
        end else if (idle_count >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_expressions();
        test_back_to_back();
        test_receiver_holdoff();
        test_random_expressions();

        s_tvalid <= 1'b0;
        while (postfix_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (errors == 0 && postfix_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
